// File: hw/rtl/ptc_pkg.sv
`default_nettype none
package ptc_pkg;

  // raw converter word
  localparam int RAW_W = 20;

  // shared multiplier operand widths
  localparam int MUL_A_W = 40;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // divider magnitudes
  localparam int DVD_W = 63;
  localparam int DVS_W = 39;

  // clamps
  localparam logic signed [63:0] NUM_LIMIT  = 64'sd2951479051793528;
  localparam logic [DVD_W-1:0]   QUOT_LIMIT = 63'h8_0000_0000;
  localparam logic signed [63:0] PRESS_MAX  = 64'sd33554431;
  localparam logic signed [35:0] TEMP_MAX   = 36'sd32767;
  localparam logic signed [35:0] TEMP_MIN   = -36'sd32768;

  // offsets and scale factors
  localparam logic signed [32:0] FINE_OFFSET = 33'sd128000;
  localparam logic signed [63:0] M_OFFSET    = 64'sh0000_8000_0000_0000;
  localparam logic signed [24:0] DIV_SCALE   = 25'sd3125;

endpackage
`default_nettype wire

// File: hw/rtl/ptc_div.sv
`default_nettype none
module ptc_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [ptc_pkg::DVD_W-1:0] dividend,
  input  wire logic [ptc_pkg::DVS_W-1:0] divisor,
  output logic                           done,
  output logic [ptc_pkg::DVD_W-1:0]      quotient
);
  import ptc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   shifted;
  logic             fits;

  // one quotient bit per cycle, restoring form
  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? DVS_W'(shifted - {1'b0, dvs_r}) : shifted[DVS_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// File: hw/rtl/pressure_temperature_compensation.sv
`default_nettype none
// channel | direction | payload
// in_     | stream in  | tdata: raw_sample; tuser: kind
// out_    | stream out | tdata: temperature_centi, pressure_q24_8; tuser: result_kind,
//         |            | pressure_invalid
// cfg_    | apb slave  | registers of up to 64 bits at byte address 8*i
//
// a pressure sample passes through the one-bit-per-cycle divider; a zero divisor
// ends the pressure path before the divider and goes straight to the output step
// one shared 40x25 multiplier does every product, one per cycle, registered
// in_tready is high only while the sequencer is idle; a result waiting on out_tready
// holds the sequencer in its last step
// synchronous active-low reset clears calibration, fine temperature and control
module pressure_temperature_compensation #(
  parameter int SAMPLE_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [19:0] raw_sample, rest zero
  input  wire logic [0:0]  in_tuser,   // [0] kind
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] temperature_centi, [40:16] pressure_q24_8
  output logic [1:0]       out_tuser,  // [0] result_kind, [1] pressure_invalid
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import ptc_pkg::*;

  // low bits dropped at reduced resolution
  localparam int DROP = RAW_W - SAMPLE_BITS;
  localparam logic [RAW_W-1:0] RAW_MASK = ~((RAW_W'(1) << DROP) - RAW_W'(1));

  // register indexes
  localparam logic [1:0] REG_TEMP_CAL = 2'd0;
  localparam logic [1:0] REG_PRESS_A  = 2'd1;
  localparam logic [1:0] REG_PRESS_B  = 2'd2;
  localparam logic [1:0] REG_PRESS_C  = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
    ST_P7, ST_P8, ST_P9, ST_P10, ST_P11, ST_P12, ST_P13,
    ST_DIV, ST_DWAIT,
    ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4,
    ST_OUT
  } state_t;

  state_t state_r, state_nxt;

  // calibration registers
  logic [47:0] temp_cal_r, temp_cal_nxt;
  logic [63:0] press_a_r, press_a_nxt;
  logic [63:0] press_b_r, press_b_nxt;
  logic [15:0] press_c_r, press_c_nxt;
  logic        cfg_write;

  // fine temperature, kept across transfers
  logic signed [31:0] fine_r, fine_nxt;

  // working registers
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic               kind_r, kind_nxt;
  logic signed [24:0] a_r, a_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] num_r, num_nxt;
  logic signed [54:0] m_r, m_nxt;
  logic signed [54:0] q_r, q_nxt;
  logic signed [39:0] d_r, d_nxt;
  logic signed [36:0] x_r, x_nxt;
  logic               sign_r, sign_nxt;
  logic signed [15:0] res_temp_r, res_temp_nxt;
  logic [24:0]        res_press_r, res_press_nxt;
  logic               res_inv_r, res_inv_nxt;

  // output register
  logic        out_tvalid_r, out_tvalid_nxt;
  logic [47:0] out_tdata_r, out_tdata_nxt;
  logic [1:0]  out_tuser_r, out_tuser_nxt;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  // calibration fields
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_cal_r[15:0];
  assign t2 = $signed(temp_cal_r[31:16]);
  assign t3 = $signed(temp_cal_r[47:32]);
  assign p1 = press_a_r[15:0];
  assign p2 = $signed(press_a_r[31:16]);
  assign p3 = $signed(press_a_r[47:32]);
  assign p4 = $signed(press_a_r[63:48]);
  assign p5 = $signed(press_b_r[15:0]);
  assign p6 = $signed(press_b_r[31:16]);
  assign p7 = $signed(press_b_r[47:32]);
  assign p8 = $signed(press_b_r[63:48]);
  assign p9 = $signed(press_c_r);

  // temperature differences
  logic signed [17:0] d1, d2;
  assign d1 = $signed({1'b0, raw_r[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2 = $signed({2'b0, raw_r[19:4]}) - $signed({2'b0, t1});

  // temperature scaling: (fine*5 + 128) >> 8
  logic signed [35:0] temp_sum, temp_sh;
  assign temp_sum = (36'(fine_r) <<< 2) + 36'(fine_r) + 36'sd128;
  assign temp_sh  = temp_sum >>> 8;

  // low part of the divisor product: carry into bit 33
  logic [33:0] lo_sum;
  assign lo_sum = {1'b0, q_r[15:0], 17'b0} + {1'b0, prod_r[32:0]};

  // first pressure term: (2^20 - raw) * 2^31
  logic [20:0] raw_span;
  assign raw_span = 21'h10_0000 - {1'b0, raw_r};

  // final pressure before clamp
  logic signed [63:0] press_val;
  assign press_val = 64'(acc_r >>> 8) + (64'(p7) <<< 4);

  // divider
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic [35:0]      quo_mag;

  assign div_start = (state_r == ST_DIV);
  assign div_dvd   = acc_r[63] ? DVD_W'(-acc_r) : acc_r[DVD_W-1:0];
  assign div_dvs   = d_r[39] ? DVS_W'(-d_r) : d_r[DVS_W-1:0];
  assign quo_mag   = (div_quo > QUOT_LIMIT) ? QUOT_LIMIT[35:0] : div_quo[35:0];

  ptc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[4:3])
      REG_TEMP_CAL: cfg_prdata = {16'b0, temp_cal_r};
      REG_PRESS_A:  cfg_prdata = press_a_r;
      REG_PRESS_B:  cfg_prdata = press_b_r;
      REG_PRESS_C:  cfg_prdata = {48'b0, press_c_r};
      default:      cfg_prdata = '0;
    endcase
  end

  always_comb begin
    temp_cal_nxt = temp_cal_r;
    press_a_nxt  = press_a_r;
    press_b_nxt  = press_b_r;
    press_c_nxt  = press_c_r;
    if (cfg_write) begin
      case (cfg_paddr[4:3])
        REG_TEMP_CAL: temp_cal_nxt = cfg_pwdata[47:0];
        REG_PRESS_A:  press_a_nxt  = cfg_pwdata;
        REG_PRESS_B:  press_b_nxt  = cfg_pwdata;
        REG_PRESS_C:  press_c_nxt  = cfg_pwdata[15:0];
        default:      temp_cal_nxt = temp_cal_r;
      endcase
    end
  end

  // sequencer: a step that uses a product takes the one started by the step before
  always_comb begin
    state_nxt      = state_r;
    fine_nxt       = fine_r;
    raw_nxt        = raw_r;
    kind_nxt       = kind_r;
    a_nxt          = a_r;
    acc_nxt        = acc_r;
    num_nxt        = num_r;
    m_nxt          = m_r;
    q_nxt          = q_r;
    d_nxt          = d_r;
    x_nxt          = x_r;
    sign_nxt       = sign_r;
    res_temp_nxt   = res_temp_r;
    res_press_nxt  = res_press_r;
    res_inv_nxt    = res_inv_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mul_a          = '0;
    mul_b          = '0;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          raw_nxt   = in_tdata[RAW_W-1:0] & RAW_MASK;
          kind_nxt  = in_tuser[0];
          a_nxt     = 25'(33'(fine_r) - FINE_OFFSET);
          state_nxt = in_tuser[0] ? ST_P0 : ST_T0;
        end
      end
      // temperature
      ST_T0: begin
        mul_a     = MUL_A_W'(d1);
        mul_b     = MUL_B_W'(t2);
        state_nxt = ST_T1;
      end
      ST_T1: begin
        acc_nxt   = 64'(prod_r >>> 11);
        mul_a     = MUL_A_W'(d2);
        mul_b     = MUL_B_W'(d2);
        state_nxt = ST_T2;
      end
      ST_T2: begin
        mul_a     = MUL_A_W'($signed({1'b0, prod_r[33:12]}));
        mul_b     = MUL_B_W'(t3);
        state_nxt = ST_T3;
      end
      ST_T3: begin
        fine_nxt  = 32'(acc_r + 64'(prod_r >>> 14));
        state_nxt = ST_T4;
      end
      ST_T4: begin
        if (temp_sh > TEMP_MAX) begin
          res_temp_nxt = TEMP_MAX[15:0];
        end else if (temp_sh < TEMP_MIN) begin
          res_temp_nxt = TEMP_MIN[15:0];
        end else begin
          res_temp_nxt = temp_sh[15:0];
        end
        res_press_nxt = '0;
        res_inv_nxt   = 1'b0;
        state_nxt     = ST_OUT;
      end
      // pressure: offset term b, built in acc then parked in num
      ST_P0: begin
        mul_a     = MUL_A_W'(a_r);
        mul_b     = MUL_B_W'(p6);
        state_nxt = ST_P1;
      end
      ST_P1: begin
        mul_a     = $signed(prod_r[MUL_A_W-1:0]);
        mul_b     = a_r;
        state_nxt = ST_P2;
      end
      ST_P2: begin
        acc_nxt   = 64'(prod_r);
        mul_a     = MUL_A_W'(a_r);
        mul_b     = MUL_B_W'(p5);
        state_nxt = ST_P3;
      end
      ST_P3: begin
        acc_nxt   = acc_r + (64'(prod_r) <<< 17);
        mul_a     = MUL_A_W'(a_r);
        mul_b     = MUL_B_W'(p3);
        state_nxt = ST_P4;
      end
      ST_P4: begin
        num_nxt   = acc_r + (64'(p4) <<< 35);
        mul_a     = $signed(prod_r[MUL_A_W-1:0]);
        mul_b     = a_r;
        state_nxt = ST_P5;
      end
      // divisor: m = 2^47 + (a*a*p3 >> 8) + a*p2*2^12, d = (m*p1) >> 33
      ST_P5: begin
        acc_nxt   = 64'(prod_r >>> 8) + M_OFFSET;
        mul_a     = MUL_A_W'(a_r);
        mul_b     = MUL_B_W'(p2);
        state_nxt = ST_P6;
      end
      ST_P6: begin
        m_nxt     = 55'(acc_r + (64'(prod_r) <<< 12));
        state_nxt = ST_P7;
      end
      ST_P7: begin
        mul_a     = MUL_A_W'(m_r >>> 17);
        mul_b     = MUL_B_W'($signed({1'b0, p1}));
        state_nxt = ST_P8;
      end
      ST_P8: begin
        q_nxt     = 55'(prod_r);
        mul_a     = MUL_A_W'($signed({1'b0, m_r[16:0]}));
        mul_b     = MUL_B_W'($signed({1'b0, p1}));
        state_nxt = ST_P9;
      end
      ST_P9: begin
        d_nxt     = 40'(q_r >>> 16) + {39'b0, lo_sum[33]};
        num_nxt   = $signed({12'b0, raw_span, 31'b0}) - num_r;
        state_nxt = ST_P10;
      end
      ST_P10: begin
        if (d_r == '0) begin
          res_temp_nxt  = '0;
          res_press_nxt = '0;
          res_inv_nxt   = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          if (num_r > NUM_LIMIT) begin
            num_nxt = NUM_LIMIT;
          end else if (num_r < -NUM_LIMIT) begin
            num_nxt = -NUM_LIMIT;
          end
          state_nxt = ST_P11;
        end
      end
      // dividend times 3125 in two halves
      ST_P11: begin
        mul_a     = MUL_A_W'(num_r >>> 26);
        mul_b     = DIV_SCALE;
        state_nxt = ST_P12;
      end
      ST_P12: begin
        acc_nxt   = 64'(prod_r) <<< 26;
        mul_a     = MUL_A_W'($signed({1'b0, num_r[25:0]}));
        mul_b     = DIV_SCALE;
        state_nxt = ST_P13;
      end
      ST_P13: begin
        acc_nxt   = acc_r + 64'(prod_r);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        sign_nxt  = acc_r[63] ^ d_r[39];
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          x_nxt     = sign_r ? -$signed({1'b0, quo_mag}) : $signed({1'b0, quo_mag});
          state_nxt = ST_Q0;
        end
      end
      // correction terms
      ST_Q0: begin
        mul_a     = MUL_A_W'(x_r >>> 13);
        mul_b     = MUL_B_W'(p9);
        state_nxt = ST_Q1;
      end
      ST_Q1: begin
        mul_a     = $signed(prod_r[MUL_A_W-1:0]);
        mul_b     = MUL_B_W'(x_r >>> 13);
        state_nxt = ST_Q2;
      end
      ST_Q2: begin
        acc_nxt   = 64'(x_r) + 64'(prod_r >>> 25);
        mul_a     = MUL_A_W'(x_r);
        mul_b     = MUL_B_W'(p8);
        state_nxt = ST_Q3;
      end
      ST_Q3: begin
        acc_nxt   = acc_r + 64'(prod_r >>> 19);
        state_nxt = ST_Q4;
      end
      ST_Q4: begin
        if (press_val[63]) begin
          res_press_nxt = '0;
        end else if (press_val > PRESS_MAX) begin
          res_press_nxt = PRESS_MAX[24:0];
        end else begin
          res_press_nxt = press_val[24:0];
        end
        res_temp_nxt = '0;
        res_inv_nxt  = 1'b0;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'b0, res_press_r, res_temp_r};
          out_tuser_nxt  = {res_inv_r, kind_r};
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      fine_r       <= '0;
      temp_cal_r   <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      fine_r       <= fine_nxt;
      temp_cal_r   <= temp_cal_nxt;
      press_a_r    <= press_a_nxt;
      press_b_r    <= press_b_nxt;
      press_c_r    <= press_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r      <= mul_a * mul_b;
    raw_r       <= raw_nxt;
    kind_r      <= kind_nxt;
    a_r         <= a_nxt;
    acc_r       <= acc_nxt;
    num_r       <= num_nxt;
    m_r         <= m_nxt;
    q_r         <= q_nxt;
    d_r         <= d_nxt;
    x_r         <= x_nxt;
    sign_r      <= sign_nxt;
    res_temp_r  <= res_temp_nxt;
    res_press_r <= res_press_nxt;
    res_inv_r   <= res_inv_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

// File: verif/tb_pressure_temperature_compensation.sv
`timescale 1ns / 100ps
module tb_pressure_temperature_compensation;
  import ptc_pkg::*;

  localparam int  CYCLE_LIMIT = 3_000_000;
  localparam int  DRAIN_WAIT  = 120;    // longer than the slowest pressure transfer
  localparam bit  KIND_TEMP   = 1'b0;
  localparam bit  KIND_PRESS  = 1'b1;
  // register byte addresses, 8*i since some registers are 64 bits wide
  localparam logic [4:0] REG_TEMP_CAL    = 5'd0;
  localparam logic [4:0] REG_PRESS_CAL_A = 5'd8;
  localparam logic [4:0] REG_PRESS_CAL_B = 5'd16;
  localparam logic [4:0] REG_PRESS_CAL_C = 5'd24;
  // typical sensor calibration and readings
  localparam logic [47:0] TYP_TEMP_CAL = {16'(-16'sd1000), 16'd26435, 16'd27504};
  localparam logic [63:0] TYP_PRESS_A  = {16'd2855, 16'd3024, 16'(-16'sd10685), 16'd36477};
  localparam logic [63:0] TYP_PRESS_B  = {16'(-16'sd14600), 16'd15500, 16'(-16'sd7), 16'd140};
  localparam logic [15:0] TYP_PRESS_C  = 16'd6000;
  localparam int TYP_RAW_TEMP  = 519888;
  localparam int TYP_RAW_PRESS = 415148;

  typedef struct packed {
    logic        kind;
    logic [15:0] temp_centi;
    logic [24:0] press_q24_8;
    logic        press_invalid;
  } reading_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;    // [19:0] raw_sample, rest zero
  logic [0:0]  in_tuser;    // [0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;   // [15:0] temperature_centi, [40:16] pressure_q24_8
  logic [1:0]  out_tuser;   // [0] result_kind, [1] pressure_invalid
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // predictor copy of the calibration and the fine temperature
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a, cal_press_b;
  logic [15:0] cal_press_c;
  logic signed [31:0] fine_temp;

  reading_t expected_readings[$];
  int error_count;
  int cycle_count;
  int idle_pct;
  int stall_pct;

  pressure_temperature_compensation #(.SAMPLE_BITS(20)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls at the current phase's rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic longint clip(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint sfield(logic [63:0] w, int pos);
    logic signed [15:0] f;
    f = w[pos +: 16];
    return longint'(f);
  endfunction

  // temperature path, updates the stored fine temperature
  function automatic logic [15:0] predict_temperature(logic [19:0] raw);
    longint r, t1, t2, t3, d1, d2, v1, v2, fine;
    r = longint'({44'd0, raw});
    t1 = longint'({48'd0, cal_temp[15:0]});
    t2 = sfield({16'd0, cal_temp}, 16);
    t3 = sfield({16'd0, cal_temp}, 32);
    d1 = (r >>> 3) - t1 * 2;
    d2 = (r >>> 4) - t1;
    v1 = (d1 * t2) >>> 11;
    v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    fine_temp = fine[31:0];
    return 16'(clip((fine * 5 + 128) >>> 8, -32768, 32767));
  endfunction

  // pressure path, uses the stored fine temperature; bad set on a zero divisor
  function automatic logic [24:0] predict_pressure(logic [19:0] raw, output logic bad);
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, b, m, mh, ml, q, qh, ql, d, num, x, s, c1, c2;
    longint num_lim, quot_lim;
    num_lim = 64'sh7FFF_FFFF_FFFF_FFFF / 3125;
    quot_lim = longint'(1) <<< 35;
    p1 = longint'({48'd0, cal_press_a[15:0]});
    p2 = sfield(cal_press_a, 16);
    p3 = sfield(cal_press_a, 32);
    p4 = sfield(cal_press_a, 48);
    p5 = sfield(cal_press_b, 0);
    p6 = sfield(cal_press_b, 16);
    p7 = sfield(cal_press_b, 32);
    p8 = sfield(cal_press_b, 48);
    p9 = sfield({48'd0, cal_press_c}, 0);
    a = longint'(fine_temp) - 128000;
    b = a * a * p6 + a * p5 * 131072 + p4 * (longint'(1) <<< 35);
    a = ((a * a * p3) >>> 8) + a * p2 * 4096;
    m = (longint'(1) <<< 47) + a;
    mh = m >>> 17;
    ml = m - mh * 131072;
    q = mh * p1;
    qh = q >>> 16;
    ql = q - qh * 65536;
    d = qh + ((ql * 131072 + ml * p1) >>> 33);
    if (d == 0) begin
      bad = 1'b1;
      return '0;
    end
    bad = 1'b0;
    num = (longint'(1048576) - longint'({44'd0, raw})) * (longint'(1) <<< 31) - b;
    num = clip(num, -num_lim, num_lim);
    x = clip((num * 3125) / d, -quot_lim, quot_lim);
    s = x >>> 13;
    c1 = (p9 * s * s) >>> 25;
    c2 = (p8 * x) >>> 19;
    x = ((x + c1 + c2) >>> 8) + p7 * 16;
    return 25'(clip(x, 0, 33554431));
  endfunction

  // one sample transfer; in_tvalid is left high for a back-to-back follower
  task automatic send_sample(logic kind, logic [19:0] raw);
    reading_t r;
    logic bad;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, raw};
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    r = '0;
    r.kind = kind;
    if (kind == KIND_TEMP) begin
      r.temp_centi = predict_temperature(raw);
    end else begin
      r.press_q24_8 = predict_pressure(raw, bad);
      r.press_invalid = bad;
    end
    expected_readings.push_back(r);
  endtask

  // stop sending and let every expected reading come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // setup cycle then access cycle; only called while the block is idle
  task automatic write_register(logic [4:0] addr, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (addr)
      REG_TEMP_CAL:    cal_temp    = value[47:0];
      REG_PRESS_CAL_A: cal_press_a = value;
      REG_PRESS_CAL_B: cal_press_b = value;
      REG_PRESS_CAL_C: cal_press_c = value[15:0];
      default: ;
    endcase
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
                                  logic [15:0] pc);
    write_register(REG_TEMP_CAL, {16'd0, tc});
    write_register(REG_PRESS_CAL_A, pa);
    write_register(REG_PRESS_CAL_B, pb);
    write_register(REG_PRESS_CAL_C, {48'd0, pc});
  endtask

  // result checker, compares each transfer with the oldest expectation
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result transfer: tdata %h tuser %b", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_tuser[0] !== exp_r.kind) begin
          $error("result_kind: expected %0d actual %0d", exp_r.kind, out_tuser[0]);
          error_count++;
        end
        if (out_tdata[15:0] !== exp_r.temp_centi) begin
          $error("temperature_centi: expected %0d actual %0d",
                 $signed(exp_r.temp_centi), $signed(out_tdata[15:0]));
          error_count++;
        end
        if (out_tdata[40:16] !== exp_r.press_q24_8) begin
          $error("pressure_q24_8: expected %0d actual %0d",
                 exp_r.press_q24_8, out_tdata[40:16]);
          error_count++;
        end
        if (out_tuser[1] !== exp_r.press_invalid) begin
          $error("pressure_invalid: expected %0d actual %0d",
                 exp_r.press_invalid, out_tuser[1]);
          error_count++;
        end
      end
    end
  end

  // reset calibration is all zero, so pressure has a zero divisor
  task automatic test_reset_state();
    send_sample(KIND_PRESS, 20'd0);
    send_sample(KIND_TEMP, 20'hFFFFF);
    send_sample(KIND_PRESS, 20'hFFFFF);
    drain_results();
  endtask

  // typical calibration, field extremes and kinds in both orders
  task automatic test_typical_readings();
    load_calibration(TYP_TEMP_CAL, TYP_PRESS_A, TYP_PRESS_B, TYP_PRESS_C);
    send_sample(KIND_PRESS, 20'(TYP_RAW_PRESS));   // fine temperature still zero
    send_sample(KIND_TEMP, 20'(TYP_RAW_TEMP));
    send_sample(KIND_PRESS, 20'(TYP_RAW_PRESS));
    send_sample(KIND_PRESS, 20'd0);
    send_sample(KIND_PRESS, 20'hFFFFF);
    send_sample(KIND_TEMP, 20'd0);
    send_sample(KIND_PRESS, 20'(TYP_RAW_PRESS));
    send_sample(KIND_TEMP, 20'hFFFFF);
    send_sample(KIND_PRESS, 20'h80000);
    send_sample(KIND_TEMP, 20'h7FFFF);
    drain_results();
  endtask

  // extreme calibrations: saturation, clamps and zero divisor with nonzero words
  task automatic test_extreme_calibration();
    load_calibration('1, '1, '1, '1);
    send_sample(KIND_TEMP, 20'd0);
    send_sample(KIND_PRESS, 20'd0);
    send_sample(KIND_PRESS, 20'hFFFFF);
    drain_results();
    load_calibration({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h8000, 16'h0001},
                     {16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000}, 16'h8000);
    send_sample(KIND_TEMP, 20'hFFFFF);
    send_sample(KIND_PRESS, 20'd0);
    send_sample(KIND_TEMP, 20'd0);
    send_sample(KIND_PRESS, 20'hFFFFF);
    drain_results();
    // p1 zero gives a zero divisor whatever the other words hold
    load_calibration(TYP_TEMP_CAL, {TYP_PRESS_A[63:16], 16'd0}, TYP_PRESS_B, 16'h7FFF);
    send_sample(KIND_TEMP, 20'(TYP_RAW_TEMP));
    send_sample(KIND_PRESS, 20'(TYP_RAW_PRESS));
    drain_results();
  endtask

  function automatic logic [15:0] nudge(logic [15:0] w, int spread);
    return w + 16'($urandom_range(2 * spread) - spread);
  endfunction

  // random calibration: mostly near a real sensor, sometimes any bits at all
  task automatic randomize_calibration();
    logic [47:0] tc;
    logic [63:0] pa, pb;
    if ($urandom_range(3) == 0) begin
      tc = 48'({$urandom, $urandom});
      pa = {$urandom, $urandom};
      pb = {$urandom, $urandom};
      load_calibration(tc, pa, pb, 16'($urandom));
    end else begin
      tc = {nudge(TYP_TEMP_CAL[47:32], 500), nudge(TYP_TEMP_CAL[31:16], 2000),
            nudge(TYP_TEMP_CAL[15:0], 2000)};
      pa = {nudge(TYP_PRESS_A[63:48], 1000), nudge(TYP_PRESS_A[47:32], 500),
            nudge(TYP_PRESS_A[31:16], 1000), nudge(TYP_PRESS_A[15:0], 3000)};
      pb = {nudge(TYP_PRESS_B[63:48], 2000), nudge(TYP_PRESS_B[47:32], 2000),
            nudge(TYP_PRESS_B[31:16], 10), nudge(TYP_PRESS_B[15:0], 100)};
      load_calibration(tc, pa, pb, nudge(TYP_PRESS_C, 1000));
    end
  endtask

  // well-formed measurement cycles (temperature then pressures) plus noise
  task automatic test_random_phase(int idle, int stall, int count);
    int sent;
    bit drained;
    idle_pct = idle;
    stall_pct = stall;
    randomize_calibration();
    sent = 0;
    drained = 1'b0;
    while (sent < count) begin
      if ($urandom_range(4) == 0) begin
        send_sample(1'($urandom), 20'($urandom));
        sent++;
      end else begin
        send_sample(KIND_TEMP, 20'(TYP_RAW_TEMP + $urandom_range(160000) - 80000));
        sent++;
        repeat ($urandom_range(1, 3)) begin
          send_sample(KIND_PRESS, 20'(TYP_RAW_PRESS + $urandom_range(300000) - 150000));
          sent++;
        end
      end
      if (!drained && sent > count / 2) begin
        // let the pipeline empty completely mid-phase
        drained = 1'b1;
        drain_results();
      end
    end
    drain_results();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    cal_temp    = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_press_c = '0;
    fine_temp   = '0;
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    stall_pct   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_typical_readings();
    test_extreme_calibration();
    test_random_phase(0, 0, 380);
    test_random_phase(47, 0, 380);
    test_random_phase(0, 47, 380);
    test_random_phase(12, 12, 380);

    if (error_count == 0 && expected_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
